/* rtl/nan_skipping_mean_difference_assert.svh */
// ----------------------------------------------------------------------------
// nan_skipping_mean_difference_assert.svh
// Assertion macros for the mean difference RTL.
// ----------------------------------------------------------------------------
`ifndef NAN_SKIPPING_MEAN_DIFFERENCE_ASSERT_SVH
`define NAN_SKIPPING_MEAN_DIFFERENCE_ASSERT_SVH

// Clocked check, suspended while reset is high.
`define NSMD_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also holds through reset.
`define NSMD_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/nsmd_pkg.sv */
// ----------------------------------------------------------------------------
// nsmd_pkg
// Types and constants for the NaN-skipping mean difference block.
// ----------------------------------------------------------------------------
package nsmd_pkg;

  localparam int DEFAULT_MAX_SAMPLES = 65536;
  localparam int SAMPLE_W            = 32;
  localparam int MEAN_W              = 33;
  localparam int COUNT_W             = 17;

  // One input transaction
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       missing;
    logic                       group;
    logic                       last;
  } item_t;

  // One result transaction
  typedef struct packed {
    logic signed [MEAN_W-1:0] mean_difference;
    logic [COUNT_W-1:0]       count_first;
    logic [COUNT_W-1:0]       count_second;
  } result_t;

  typedef enum logic [2:0] {
    ST_ACCUM,
    ST_LOAD_A,
    ST_DIV_A,
    ST_LOAD_B,
    ST_DIV_B,
    ST_FINISH
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic accept;       // take the input transaction into the accumulators
    logic load_first;   // load divider with first group sum and count
    logic load_second;  // save first mean, load divider with second group
    logic step;         // one restoring division step
    logic finish;       // write result register and clear accumulators
  } ctrl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic out_busy;     // result register holds a transaction not yet taken
  } ctrl_status_t;

endpackage

/* rtl/nsmd_datapath.sv */
// ----------------------------------------------------------------------------
// nsmd_datapath
// Per-group accumulators, shared bit-serial divider and result register.
// ----------------------------------------------------------------------------
module nsmd_datapath import nsmd_pkg::*; #(
  parameter int MAX_SAMPLES = DEFAULT_MAX_SAMPLES
) (
  input  logic         clk,
  input  logic         rst,
  input  ctrl_cmd_t    cmd,
  output ctrl_status_t status,
  input  item_t        item,
  output result_t      result,
  output logic         result_valid,
  input  logic         result_ready
);

  localparam int SUM_W = SAMPLE_W + $clog2(MAX_SAMPLES);
  localparam int CNT_W = $clog2(MAX_SAMPLES + 1);

  logic signed [SUM_W-1:0] sum_first;
  logic signed [SUM_W-1:0] sum_second;
  logic [CNT_W-1:0]        tally_first;
  logic [CNT_W-1:0]        tally_second;

  logic [CNT_W-1:0]        rem;
  logic [SUM_W-1:0]        quo;
  logic [CNT_W-1:0]        divisor;
  logic                    neg;
  logic signed [MEAN_W-1:0] mean_first;

  logic [CNT_W:0]          trial;
  logic [CNT_W:0]          trial_sub;
  logic                    trial_ge;
  logic [MEAN_W-1:0]       mag_mean;
  logic signed [MEAN_W-1:0] cur_mean;
  logic signed [SUM_W-1:0] sample_ext;
  logic                    room_first;
  logic                    room_second;

  function automatic logic [SUM_W-1:0] magnitude(input logic signed [SUM_W-1:0] v);
    magnitude = v[SUM_W-1] ? (~v + 1'b1) : v;
  endfunction

  // Division step and signed mean of the current quotient
  always_comb begin
    trial     = {rem, quo[SUM_W-1]};
    trial_sub = trial - {1'b0, divisor};
    trial_ge  = (trial >= {1'b0, divisor});
    mag_mean  = MEAN_W'(quo);
    if (divisor == '0) begin
      cur_mean = '0;
    end else if (neg) begin
      cur_mean = -$signed(mag_mean);
    end else begin
      cur_mean = $signed(mag_mean);
    end
  end

  assign sample_ext  = SUM_W'(item.sample);
  assign room_first  = (tally_first < CNT_W'(MAX_SAMPLES));
  assign room_second = (tally_second < CNT_W'(MAX_SAMPLES));

  // Accumulate non-missing samples while the group has room; clear on reset or when the result is written
  always_ff @(posedge clk) begin
    if (rst || cmd.finish) begin
      sum_first    <= '0;
      sum_second   <= '0;
      tally_first  <= '0;
      tally_second <= '0;
    end else if (cmd.accept && !item.missing) begin
      if (!item.group && room_first) begin
        sum_first   <= sum_first + sample_ext;
        tally_first <= tally_first + 1'b1;
      end
      if (item.group && room_second) begin
        sum_second   <= sum_second + sample_ext;
        tally_second <= tally_second + 1'b1;
      end
    end
  end

  // Divider registers: load a group, then shift one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (cmd.load_first) begin
      quo     <= magnitude(sum_first);
      rem     <= '0;
      divisor <= tally_first;
      neg     <= sum_first[SUM_W-1];
    end else if (cmd.load_second) begin
      mean_first <= cur_mean;
      quo        <= magnitude(sum_second);
      rem        <= '0;
      divisor    <= tally_second;
      neg        <= sum_second[SUM_W-1];
    end else if (cmd.step) begin
      rem <= trial_ge ? trial_sub[CNT_W-1:0] : trial[CNT_W-1:0];
      quo <= {quo[SUM_W-2:0], trial_ge};
    end
  end

  // Result register; hold until the transaction is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.finish) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      result.mean_difference <= mean_first - cur_mean;
      result.count_first     <= COUNT_W'(tally_first);
      result.count_second    <= COUNT_W'(tally_second);
    end
  end

  assign status.out_busy = result_valid && !result_ready;

endmodule

/* rtl/nsmd_controller.sv */
// ----------------------------------------------------------------------------
// nsmd_controller
// Sequences accumulation, the two group divisions and the result write.
// ----------------------------------------------------------------------------
`include "nan_skipping_mean_difference_assert.svh"

module nsmd_controller import nsmd_pkg::*; #(
  parameter int MAX_SAMPLES = DEFAULT_MAX_SAMPLES
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         item_valid,
  input  logic         item_last,
  output logic         item_ready,
  input  ctrl_status_t status,
  output ctrl_cmd_t    cmd
);

  localparam int SUM_W  = SAMPLE_W + $clog2(MAX_SAMPLES);
  localparam int STEP_W = $clog2(SUM_W);

  state_t              state;
  state_t              state_next;
  logic [STEP_W-1:0]   step;
  logic [STEP_W-1:0]   step_next;
  logic                step_done;

  assign step_done = (step == STEP_W'(SUM_W - 1));

  // Next state and step counter
  always_comb begin
    state_next = state;
    step_next  = step;
    case (state)
      ST_ACCUM: begin
        if (item_valid && item_last) begin
          state_next = ST_LOAD_A;
        end
      end
      ST_LOAD_A: begin
        state_next = ST_DIV_A;
        step_next  = '0;
      end
      ST_DIV_A: begin
        step_next = step + 1'b1;
        if (step_done) begin
          state_next = ST_LOAD_B;
        end
      end
      ST_LOAD_B: begin
        state_next = ST_DIV_B;
        step_next  = '0;
      end
      ST_DIV_B: begin
        step_next = step + 1'b1;
        if (step_done) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!status.out_busy) begin
          state_next = ST_ACCUM;
        end
      end
      default: begin
        state_next = ST_ACCUM;
      end
    endcase
  end

  // Commands for the datapath
  always_comb begin
    item_ready      = 1'b0;
    cmd             = '0;
    case (state)
      ST_ACCUM: begin
        item_ready = 1'b1;
        cmd.accept = item_valid;
      end
      ST_LOAD_A: cmd.load_first  = 1'b1;
      ST_DIV_A:  cmd.step        = 1'b1;
      ST_LOAD_B: cmd.load_second = 1'b1;
      ST_DIV_B:  cmd.step        = 1'b1;
      ST_FINISH: cmd.finish      = !status.out_busy;
      default: begin
        item_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_ACCUM;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

  `NSMD_ASSERT(a_last_starts_div, clk, rst, (cmd.accept && item_last) |=> (state == ST_LOAD_A), "last transaction did not start division")
  `NSMD_ASSERT(a_step_in_range, clk, rst, (state == ST_DIV_A || state == ST_DIV_B) |-> (step <= STEP_W'(SUM_W - 1)), "division step counter out of range")
  `NSMD_ASSERT(a_finish_returns, clk, rst, (state == ST_FINISH && !status.out_busy) |=> (state == ST_ACCUM), "finish did not return to accumulation")

endmodule

/* rtl/nan_skipping_mean_difference.sv */
// After the last transaction is accepted, the two group means are divided in turn by the
//   one-bit-per-cycle divider and the result is written once the result register is free.
// Throughput: one sample per cycle; input is held off during division and the result write.
// The result register lets accumulation resume while a result waits to be taken.
// Reset (synchronous, active high) clears sums, counts, the controller and result valid.
// ----------------------------------------------------------------------------
// nan_skipping_mean_difference
// Difference of two group means over a stream of Q16.16 samples, skipping NaN.
// ----------------------------------------------------------------------------
module nan_skipping_mean_difference import nsmd_pkg::*; #(
  parameter int MAX_SAMPLES = DEFAULT_MAX_SAMPLES
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_ready,
  input  item_t   item,
  output logic    result_valid,
  input  logic    result_ready,
  output result_t result
);

  ctrl_cmd_t    cmd;
  ctrl_status_t status;

  nsmd_controller #(
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_controller (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_last  (item.last),
    .item_ready (item_ready),
    .status     (status),
    .cmd        (cmd)
  );

  nsmd_datapath #(
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .item         (item),
    .result       (result),
    .result_valid (result_valid),
    .result_ready (result_ready)
  );

endmodule
